// ===== rtl/wfr_pkg.sv =====
// Shared types, widths and constants for the world-to-body frame rotation.
// Holds the request/result structs, the CORDIC cell data and the arctangent table.
// No dependencies.
`default_nettype none

package wfr_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int COORD_FRAC_BITS_DEF = 8;
    localparam int ATAN_ENTRIES        = 24;

    localparam int ANG_W = 16;
    localparam int POS_W = 32;
    localparam int CM_W  = 32;
    localparam int D_W   = POS_W + 1;
    localparam int Z_W   = 33;
    localparam int XY_W  = 34;
    localparam int SC_W  = 32;
    localparam int P_W   = D_W + SC_W;
    localparam int R_W   = P_W + 1;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic signed [Z_W-1:0]  ANG_QUARTER     = 33'sh040000000;
    localparam logic signed [Z_W-1:0]  ANG_HALF        = 33'sh080000000;

    typedef struct packed {
        logic signed [ANG_W-1:0] yaw_angle;
        logic signed [POS_W-1:0] target_east;
        logic signed [POS_W-1:0] target_north;
        logic signed [POS_W-1:0] vehicle_east;
        logic signed [POS_W-1:0] vehicle_north;
    } wfr_req_t;

    typedef struct packed {
        logic signed [CM_W-1:0] body_x_cm;
        logic signed [CM_W-1:0] body_y_cm;
    } wfr_res_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic                   flip;
    } wfr_cell_t;

    function automatic logic signed [Z_W-1:0] atan_units(input int unsigned idx);
        logic signed [Z_W-1:0] a;
        unique case (idx)
            0:       a = 33'sh020000000;
            1:       a = 33'sh012E4051E;
            2:       a = 33'sh009FB385B;
            3:       a = 33'sh0051111D4;
            4:       a = 33'sh0028B0D43;
            5:       a = 33'sh00145D7E1;
            6:       a = 33'sh000A2F61E;
            7:       a = 33'sh000517C55;
            8:       a = 33'sh00028BE53;
            9:       a = 33'sh000145F2F;
            10:      a = 33'sh0000A2F98;
            11:      a = 33'sh0000517CC;
            12:      a = 33'sh000028BE6;
            13:      a = 33'sh0000145F3;
            14:      a = 33'sh00000A2FA;
            15:      a = 33'sh00000517D;
            16:      a = 33'sh0000028BE;
            17:      a = 33'sh00000145F;
            18:      a = 33'sh000000A30;
            19:      a = 33'sh000000518;
            20:      a = 33'sh00000028C;
            21:      a = 33'sh000000146;
            22:      a = 33'sh0000000A3;
            23:      a = 33'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wfr_cordic_cell.sv =====
// One rotation-mode CORDIC cell: a single micro-rotation by atan(2^-IDX).
// Passes the difference vector and fold flag to the next cell.
// Depends on wfr_pkg.
`default_nettype none

module wfr_cordic_cell
    import wfr_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire wfr_cell_t in_data,
    output logic           out_valid,
    output wfr_cell_t      out_data
);

    localparam logic signed [Z_W-1:0] ATAN = atan_units(IDX);

    logic                   valid_reg;
    wfr_cell_t              data_reg;
    wfr_cell_t              data_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb
    begin
        xs        = in_data.x >>> IDX;
        ys        = in_data.y >>> IDX;
        data_next = in_data;
        if (!in_data.z[Z_W-1])
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/wfr_rotate.sv =====
// Rotates the difference vector by the CORDIC sine and cosine.
// Three stages: undo the fold, four products, sum and difference.
// Depends on wfr_pkg.
`default_nettype none

module wfr_rotate
    import wfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire wfr_cell_t in_data,
    output logic           out_valid,
    output logic signed [R_W-1:0] rot_x,
    output logic signed [R_W-1:0] rot_y
);

    logic [2:0]             valid_reg;
    logic signed [XY_W-1:0] c_next;
    logic signed [XY_W-1:0] s_next;
    logic signed [SC_W-1:0] c_reg;
    logic signed [SC_W-1:0] s_reg;
    logic signed [D_W-1:0]  dx_reg;
    logic signed [D_W-1:0]  dy_reg;
    logic signed [P_W-1:0]  xc_reg;
    logic signed [P_W-1:0]  ys_reg;
    logic signed [P_W-1:0]  yc_reg;
    logic signed [P_W-1:0]  xs_reg;
    logic signed [R_W-1:0]  rx_reg;
    logic signed [R_W-1:0]  ry_reg;

    always_comb
    begin
        c_next = in_data.flip ? -in_data.x : in_data.x;
        s_next = in_data.flip ? -in_data.y : in_data.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg  <= $signed(c_next[SC_W-1:0]);
        s_reg  <= $signed(s_next[SC_W-1:0]);
        dx_reg <= in_data.dx;
        dy_reg <= in_data.dy;
        xc_reg <= dx_reg * c_reg;
        ys_reg <= dy_reg * s_reg;
        yc_reg <= dy_reg * c_reg;
        xs_reg <= dx_reg * s_reg;
        rx_reg <= R_W'(xc_reg) - R_W'(ys_reg);
        ry_reg <= R_W'(yc_reg) + R_W'(xs_reg);
    end

    assign out_valid = valid_reg[2];
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;

endmodule

`default_nettype wire

// ===== rtl/wfr_to_cm.sv =====
// Converts the two rotated sums to centimetres: magnitude, times 100 by
// shift and add, truncate toward zero, saturate. Four stages.
// Depends on wfr_pkg.
`default_nettype none

module wfr_to_cm
    import wfr_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic signed [R_W-1:0] rot_x,
    input  wire logic signed [R_W-1:0] rot_y,
    output logic                  out_valid,
    output wfr_res_t              result
);

    localparam int SH    = COORD_FRAC_BITS + 30;
    localparam int MAG_W = R_W;
    localparam int M3_W  = MAG_W + 2;
    localparam int PR_W  = MAG_W + 7;
    localparam int CMW   = PR_W - SH;
    localparam logic [PR_W-1:0] POS_LIMIT = PR_W'(64'h7FFFFFFF);
    localparam logic [PR_W-1:0] NEG_LIMIT = PR_W'(64'h80000000);

    logic [3:0]             valid_reg;
    logic signed [R_W-1:0]  rot [2];
    logic [2:0]             neg_reg [2];
    logic [MAG_W-1:0]       mag_reg [2];
    logic [MAG_W-1:0]       mag2_reg [2];
    logic [M3_W-1:0]        m3_reg [2];
    logic [PR_W-1:0]        prod [2];
    logic [PR_W-1:0]        prod_sh [2];
    logic [CMW-1:0]         cm_reg [2];
    logic [PR_W-1:0]        cm_ext [2];
    logic [PR_W-1:0]        cm_neg [2];
    logic [CM_W-1:0]        sat_next [2];
    logic [CM_W-1:0]        sat_reg [2];

    assign rot[0] = rot_x;
    assign rot[1] = rot_y;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            prod[k]    = (PR_W'(m3_reg[k]) << 5) + (PR_W'(mag2_reg[k]) << 2);
            prod_sh[k] = prod[k] >> SH;
            cm_ext[k]  = PR_W'(cm_reg[k]);
            cm_neg[k]  = PR_W'(0) - cm_ext[k];
            if (neg_reg[k][2])
            begin
                sat_next[k] = (cm_ext[k] > NEG_LIMIT) ? NEG_LIMIT[CM_W-1:0]
                                                      : cm_neg[k][CM_W-1:0];
            end
            else
            begin
                sat_next[k] = (cm_ext[k] > POS_LIMIT) ? POS_LIMIT[CM_W-1:0]
                                                      : cm_ext[k][CM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            neg_reg[k]  <= {neg_reg[k][1:0], rot[k][R_W-1]};
            mag_reg[k]  <= rot[k][R_W-1] ? MAG_W'(-rot[k]) : MAG_W'(rot[k]);
            m3_reg[k]   <= (M3_W'(mag_reg[k]) << 1) + M3_W'(mag_reg[k]);
            mag2_reg[k] <= mag_reg[k];
            cm_reg[k]   <= prod_sh[k][CMW-1:0];
            sat_reg[k]  <= sat_next[k];
        end
    end

    assign out_valid        = valid_reg[3];
    assign result.body_x_cm = $signed(sat_reg[0]);
    assign result.body_y_cm = $signed(sat_reg[1]);

endmodule

`default_nettype wire

// ===== rtl/world_to_body_frame_rotation_top.sv =====
// World-to-body frame rotation: target position in the vehicle frame, in cm.
// Throughput: one request per cycle; busy stays low, set by the unrolled
// CORDIC cell chain and the pipelined multiply and scale stages.
// Results appear on done for one cycle each; the receiver cannot stall.
// Reset clears only the valid pipeline; no request is in flight afterwards.
`default_nettype none

module world_to_body_frame_rotation_top
    import wfr_pkg::*;
#(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire wfr_req_t request,
    output logic          done,
    output wfr_res_t      result
);

    localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic                  in_valid_reg;
    wfr_cell_t             in_data_reg;
    wfr_cell_t             in_data_next;
    logic signed [Z_W-1:0] z0;
    logic                  chain_valid [NCELL+1];
    wfr_cell_t             chain_data [NCELL+1];
    logic                  rot_valid;
    logic signed [R_W-1:0] rot_x;
    logic signed [R_W-1:0] rot_y;

    assign busy = 1'b0;

    always_comb
    begin
        z0 = $signed({request.yaw_angle[ANG_W-1], request.yaw_angle, 16'b0});
        in_data_next.x  = CORDIC_GAIN_Q30;
        in_data_next.y  = '0;
        in_data_next.dx = D_W'(request.target_east) - D_W'(request.vehicle_east);
        in_data_next.dy = D_W'(request.target_north) - D_W'(request.vehicle_north);
        priority if (z0 > ANG_QUARTER)
        begin
            in_data_next.z    = z0 - ANG_HALF;
            in_data_next.flip = 1'b1;
        end
        else if (z0 < -ANG_QUARTER)
        begin
            in_data_next.z    = z0 + ANG_HALF;
            in_data_next.flip = 1'b1;
        end
        else
        begin
            in_data_next.z    = z0;
            in_data_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        wfr_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    wfr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NCELL]),
        .in_data   (chain_data[NCELL]),
        .out_valid (rot_valid),
        .rot_x     (rot_x),
        .rot_y     (rot_y)
    );

    wfr_to_cm #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_to_cm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .out_valid (done),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== dv/wfr_frame_scoreboard.sv =====
// Scoreboard for the world-to-body frame rotation: predicts body-frame cm results
// from each accepted request and checks the block's results in order.
// Depends on wfr_pkg for the request/result structs and widths.
`timescale 1ns / 1ps

package wfr_tb_pkg;

    import wfr_pkg::*;

    class wfr_frame_scoreboard;

        localparam int MAX_REPORTS = 40;

        wfr_res_t expected_cm[$];
        int       n_checked;
        int       n_errors;

        function new();
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function int pending();
            return expected_cm.size();
        endfunction

        function longint arctan_step(int i);
            case (i)
                0:       return 64'h20000000;
                1:       return 64'h12E4051E;
                2:       return 64'h09FB385B;
                3:       return 64'h051111D4;
                4:       return 64'h028B0D43;
                5:       return 64'h0145D7E1;
                6:       return 64'h00A2F61E;
                7:       return 64'h00517C55;
                8:       return 64'h0028BE53;
                9:       return 64'h00145F2F;
                10:      return 64'h000A2F98;
                11:      return 64'h000517CC;
                12:      return 64'h00028BE6;
                13:      return 64'h000145F3;
                14:      return 64'h0000A2FA;
                15:      return 64'h0000517D;
                16:      return 64'h000028BE;
                17:      return 64'h0000145F;
                18:      return 64'h00000A30;
                19:      return 64'h00000518;
                20:      return 64'h0000028C;
                21:      return 64'h00000146;
                22:      return 64'h000000A3;
                23:      return 64'h00000051;
                default: return 64'h0;
            endcase
        endfunction

        function logic signed [CM_W-1:0] scale_to_cm(longint rot);
            longint unsigned mag;
            longint unsigned q;
            longint unsigned r;
            longint unsigned cm;
            int unsigned     sh;
            sh  = COORD_FRAC_BITS_DEF + 30;
            mag = rot;
            if (rot < 0)
                mag = -rot;
            q  = mag >> sh;
            r  = mag & ((64'd1 << sh) - 64'd1);
            cm = q * 100 + ((r * 100) >> sh);
            if (rot < 0)
            begin
                if (cm > 64'd2147483648)
                    return 32'sh80000000;
                return CM_W'(-cm);
            end
            if (cm > 64'd2147483647)
                return 32'sh7FFFFFFF;
            return CM_W'(cm);
        endfunction

        function wfr_res_t predict_body_cm(wfr_req_t req);
            longint   z;
            longint   x;
            longint   y;
            longint   xs;
            longint   ys;
            longint   dx;
            longint   dy;
            bit       flip;
            wfr_res_t res;
            z    = longint'(req.yaw_angle) * 65536;
            x    = longint'(CORDIC_GAIN_Q30);
            y    = 0;
            flip = 1'b0;
            if (z > longint'(ANG_QUARTER))
            begin
                z    = z - longint'(ANG_HALF);
                flip = 1'b1;
            end
            else if (z < -longint'(ANG_QUARTER))
            begin
                z    = z + longint'(ANG_HALF);
                flip = 1'b1;
            end
            for (int i = 0; i < CORDIC_STAGES_DEF && i < ATAN_ENTRIES; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_step(i);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_step(i);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            dx = longint'(req.target_east) - longint'(req.vehicle_east);
            dy = longint'(req.target_north) - longint'(req.vehicle_north);
            res.body_x_cm = scale_to_cm(dx * x - dy * y);
            res.body_y_cm = scale_to_cm(dy * x + dx * y);
            return res;
        endfunction

        function void note_request(wfr_req_t req);
            expected_cm.push_back(predict_body_cm(req));
        endfunction

        function void report_field(string field, longint exp_v, longint got_v, bit got_x);
            n_errors++;
            if (n_errors <= MAX_REPORTS)
            begin
                if (got_x)
                    $display("%0t: %s mismatch, expected %0d, got unknown bits",
                             $time, field, exp_v);
                else
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, field, exp_v, got_v);
            end
            else if (n_errors == MAX_REPORTS + 1)
                $display("%0t: further mismatches counted but not shown", $time);
        endfunction

        function void check_result(wfr_res_t got);
            wfr_res_t exp_r;
            if (expected_cm.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with no request outstanding, got x=%0d y=%0d",
                         $time, got.body_x_cm, got.body_y_cm);
                return;
            end
            exp_r = expected_cm.pop_front();
            n_checked++;
            if (got.body_x_cm !== exp_r.body_x_cm)
                report_field("body_x_cm", exp_r.body_x_cm, got.body_x_cm,
                             $isunknown(got.body_x_cm));
            if (got.body_y_cm !== exp_r.body_y_cm)
                report_field("body_y_cm", exp_r.body_y_cm, got.body_y_cm,
                             $isunknown(got.body_y_cm));
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level testbench for world_to_body_frame_rotation_top: drives directed and
// random requests under several sender pacings and checks every result.
// Depends on wfr_pkg and the scoreboard in wfr_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

    import wfr_pkg::*;
    import wfr_tb_pkg::*;

    localparam int SETTLE_CYCLES  = CORDIC_STAGES_DEF + 8 + 4;
    localparam int WATCHDOG_LIMIT = 4000;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    wfr_req_t request = '0;
    logic     busy;
    logic     done;
    wfr_res_t result;

    wfr_frame_scoreboard sb;
    int                  n_requests  = 0;
    int                  idle_cycles = 0;

    world_to_body_frame_rotation_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(request);
                n_requests++;
            end
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request or result accepted for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(input wfr_req_t req, input int idle_pct);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_directed(input logic signed [ANG_W-1:0] yaw,
                                 input logic signed [POS_W-1:0] te,
                                 input logic signed [POS_W-1:0] tn,
                                 input logic signed [POS_W-1:0] ve,
                                 input logic signed [POS_W-1:0] vn);
        wfr_req_t req;
        req = '{yaw, te, tn, ve, vn};
        send_request(req, 0);
    endtask

    task automatic run_phase(input int n_items, input int idle_pct);
        wfr_req_t req;
        int       off_e;
        int       off_n;
        int       span;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(9) < 7)
                req.yaw_angle = ANG_W'($urandom);
            else
            begin
                case ($urandom_range(7))
                    0:       req.yaw_angle = 16'sh0000;
                    1:       req.yaw_angle = 16'sh4000;
                    2:       req.yaw_angle = -16'sh4000;
                    3:       req.yaw_angle = 16'sh7FFF;
                    4:       req.yaw_angle = 16'sh8000;
                    5:       req.yaw_angle = 16'sh2000;
                    6:       req.yaw_angle = -16'sh2000;
                    default: req.yaw_angle = 16'sh6000;
                endcase
                req.yaw_angle = req.yaw_angle + $signed(3'($urandom_range(2))) - 16'sd1;
            end
            case ($urandom_range(9))
                6, 7:
                begin
                    req.target_east   = $urandom;
                    req.target_north  = $urandom;
                    req.vehicle_east  = $urandom;
                    req.vehicle_north = $urandom;
                end
                8:
                begin
                    req.target_east   = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                    req.target_north  = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                    req.vehicle_east  = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
                    req.vehicle_north = $urandom_range(1) ? 32'sh00000000 : 32'shFFFFFFFF;
                end
                default:
                begin
                    span  = ($urandom_range(9) == 9) ? 32'h10000000 : 32'h00100000;
                    off_e = int'($urandom_range(2 * span)) - span;
                    off_n = int'($urandom_range(2 * span)) - span;
                    req.vehicle_east  = $urandom;
                    req.vehicle_north = $urandom;
                    req.target_east   = req.vehicle_east + off_e;
                    req.target_north  = req.vehicle_north + off_n;
                end
            endcase
            send_request(req, idle_pct);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_directed(16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_directed(16'sd0, 32'sd256000, -32'sd128000, 32'sd1280, 32'sd2560);
        send_directed(16'sh4000, 32'sd256, 32'sd0, 32'sd0, 32'sd0);
        send_directed(-16'sh4000, 32'sd256, 32'sd512, 32'sd0, 32'sd0);
        send_directed(16'sh4001, 32'sd25600, 32'sd12800, 32'sd0, 32'sd0);
        send_directed(-16'sh4001, 32'sd25600, 32'sd12800, 32'sd0, 32'sd0);
        send_directed(16'sh7FFF, 32'sd25600, -32'sd5120, 32'sd0, 32'sd0);
        send_directed(16'sh8000, 32'sd25600, -32'sd5120, 32'sd0, 32'sd0);
        send_directed(16'sh2000, 32'sd25600, 32'sd0, 32'sd0, 32'sd0);
        send_directed(16'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        send_directed(16'sh8000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        send_directed(16'sh4000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        send_directed(16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        send_directed(16'sd0, -32'sd1, 32'sd1, 32'sd0, 32'sd0);
        send_directed(16'sd0, -32'sd3, 32'sd3, 32'sd0, 32'sd0);
        send_directed(16'sd0, 32'sh01000000, 32'sd0, -32'sh01000000, 32'sd0);
        send_directed(-16'sh2000, 32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'sh55555555);
        send_directed(16'sh1234, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh00000000, 32'sh00000000);
        drain_results();

        run_phase(300, 0);
        drain_results();
        run_phase(250, 81);
        drain_results();
        run_phase(250, 14);
        drain_results();
        run_phase(300, 0);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.n_errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("Sent %0d requests (directed yaw folds, -pi, saturating spans, random)",
                 n_requests);
        $display("under 0, 81 and 14 percent sender idling; %0d results checked, %0d errors",
                 sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wfr_pkg.sv
rtl/wfr_cordic_cell.sv
rtl/wfr_rotate.sv
rtl/wfr_to_cm.sv
rtl/world_to_body_frame_rotation_top.sv
dv/wfr_frame_scoreboard.sv
dv/tb_top.sv
